// ===== sv/ipwfd_pkg.sv =====
// Shared types, event and phase codes, and interval windows for the IR frame decoder.
// No dependencies; every other file but ipwfd_out_if uses this package.
package ipwfd_pkg;

    localparam int unsigned TIME_WIDTH_DEF  = 16;
    localparam int unsigned FRAME_BYTES_DEF = 5;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned WIN_W        = 32;
    localparam int unsigned TICKS_PER_MS = 2000;

    localparam logic [WIN_W-1:0] WIN_LEAD_MARK_LO  = WIN_W'(TICKS_PER_MS * 300 / 100);
    localparam logic [WIN_W-1:0] WIN_LEAD_MARK_HI  = WIN_W'(TICKS_PER_MS * 1400 / 100);
    localparam logic [WIN_W-1:0] WIN_BIT_MARK_LO   = WIN_W'(TICKS_PER_MS * 40 / 100);
    localparam logic [WIN_W-1:0] WIN_BIT_MARK_HI   = WIN_W'(TICKS_PER_MS * 200 / 100);
    localparam logic [WIN_W-1:0] WIN_LEAD_SPACE_LO = WIN_W'(TICKS_PER_MS * 250 / 100);
    localparam logic [WIN_W-1:0] WIN_LEAD_SPACE_HI = WIN_W'(TICKS_PER_MS * 600 / 100);
    localparam logic [WIN_W-1:0] WIN_ONE_SPACE_LO  = WIN_W'(TICKS_PER_MS * 105 / 100);
    localparam logic [WIN_W-1:0] WIN_ONE_SPACE_HI  = WIN_W'(TICKS_PER_MS * 200 / 100);
    localparam logic [WIN_W-1:0] WIN_ZERO_SPACE_LO = WIN_W'(TICKS_PER_MS * 20 / 100);
    localparam logic [WIN_W-1:0] WIN_ZERO_SPACE_HI = WIN_W'(TICKS_PER_MS * 100 / 100);
    localparam logic [WIN_W-1:0] WIN_GAP_LO        = WIN_W'(TICKS_PER_MS * 1200 / 100);
    localparam logic [WIN_W-1:0] WIN_GAP_HI        = WIN_W'(TICKS_PER_MS * 2800 / 100);

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_LEAD_MARK  = 3'd1,
        EV_LEAD_SPACE = 3'd2,
        EV_BIT_MARK   = 3'd3,
        EV_ONE_SPACE  = 3'd4,
        EV_ZERO_SPACE = 3'd5,
        EV_REPEAT_GAP = 3'd6,
        EV_TIMEOUT    = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_LEADER   = 2'd1,
        PH_HEADER   = 2'd2,
        PH_BIT_MARK = 2'd3
    } t_phase;

    typedef struct packed {
        logic   valid;
        t_event ev;
    } t_ev_push;

    typedef struct packed {
        logic [2:0] event_code;
        logic [1:0] decoder_phase;
        logic       bit_valid;
        logic       bit_value;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [2:0] byte_position;
        logic       frame_end;
        logic       overflow;
    } t_result;

endpackage

// ===== sv/ipwfd_in_if.sv =====
// Input channel: edge capture or timeout tick transactions with valid/ready.
// Depends on ipwfd_pkg for the default timestamp width.
interface ipwfd_in_if #(
    parameter int unsigned TIME_WIDTH = ipwfd_pkg::TIME_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [TIME_WIDTH-1:0] timestamp;

    modport source (output valid, output op, output timestamp, input ready);
    modport sink   (input valid, input op, input timestamp, output ready);
endinterface

// ===== sv/ipwfd_out_if.sv =====
// Result channel: one decoded result per transaction with valid/ready.
// No package dependencies.
interface ipwfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [1:0] decoder_phase;
    logic       bit_valid;
    logic       bit_value;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] byte_position;
    logic       frame_end;
    logic       overflow;

    modport source (
        output valid, output event_code, output decoder_phase, output bit_valid,
        output bit_value, output byte_valid, output byte_value, output byte_position,
        output frame_end, output overflow, input ready
    );
    modport sink (
        input valid, input event_code, input decoder_phase, input bit_valid,
        input bit_value, input byte_valid, input byte_value, input byte_position,
        input frame_end, input overflow, output ready
    );
endinterface

// ===== sv/ipwfd_front.sv =====
// Front end: accepts input transactions, tracks edge polarity and timing, classifies events.
// Depends on ipwfd_pkg and ipwfd_in_if; feeds the event queue.
module ipwfd_front #(
    parameter int unsigned TIME_WIDTH = ipwfd_pkg::TIME_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ipwfd_in_if.sink            i_in,
    input  logic                i_q_full,
    output ipwfd_pkg::t_ev_push o_push
);
    import ipwfd_pkg::*;

    logic [TIME_WIDTH-1:0] r_last_time, n_last_time;
    logic                  r_armed, n_armed;
    logic                  r_expect_rising, n_expect_rising;
    logic                  r_edge_since_tick, n_edge_since_tick;

    logic                  accept;
    logic [TIME_WIDTH-1:0] ts;
    logic [TIME_WIDTH-1:0] delta;
    logic [WIN_W-1:0]      delta_ext;
    t_event                edge_ev;
    t_event                ev;

    function automatic logic in_win(logic [WIN_W-1:0] d, logic [WIN_W-1:0] lo,
                                    logic [WIN_W-1:0] hi);
        return (d > lo) && (d < hi);
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign ts         = TIME_WIDTH'(i_in.timestamp);
    assign delta      = ts - r_last_time;
    assign delta_ext  = WIN_W'(delta);

    always_comb begin
        edge_ev = EV_NONE;
        if (r_expect_rising) begin
            if (in_win(delta_ext, WIN_LEAD_MARK_LO, WIN_LEAD_MARK_HI)) begin
                edge_ev = EV_LEAD_MARK;
            end else if (in_win(delta_ext, WIN_BIT_MARK_LO, WIN_BIT_MARK_HI)) begin
                edge_ev = EV_BIT_MARK;
            end
        end else begin
            if (in_win(delta_ext, WIN_LEAD_SPACE_LO, WIN_LEAD_SPACE_HI)) begin
                edge_ev = EV_LEAD_SPACE;
            end else if (in_win(delta_ext, WIN_ONE_SPACE_LO, WIN_ONE_SPACE_HI)) begin
                edge_ev = EV_ONE_SPACE;
            end else if (in_win(delta_ext, WIN_ZERO_SPACE_LO, WIN_ZERO_SPACE_HI)) begin
                edge_ev = EV_ZERO_SPACE;
            end else if (in_win(delta_ext, WIN_GAP_LO, WIN_GAP_HI)) begin
                edge_ev = EV_REPEAT_GAP;
            end
        end
    end

    always_comb begin
        n_last_time       = r_last_time;
        n_armed           = r_armed;
        n_expect_rising   = r_expect_rising;
        n_edge_since_tick = r_edge_since_tick;
        ev                = EV_NONE;
        if (accept) begin
            if (i_in.op) begin
                // tick with no edge since the last one: disarm and end the frame
                if (!r_edge_since_tick) begin
                    n_expect_rising = 1'b0;
                    n_armed         = 1'b0;
                    ev              = EV_TIMEOUT;
                end
                n_edge_since_tick = 1'b0;
            end else begin
                n_edge_since_tick = 1'b1;
                n_last_time       = ts;
                n_expect_rising   = !r_expect_rising;
                n_armed           = 1'b1;
                if (r_armed) begin
                    ev = edge_ev;
                end
            end
        end
    end

    assign o_push.valid = accept;
    assign o_push.ev    = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time       <= '0;
            r_armed           <= 1'b0;
            r_expect_rising   <= 1'b0;
            r_edge_since_tick <= 1'b0;
        end else begin
            r_last_time       <= n_last_time;
            r_armed           <= n_armed;
            r_expect_rising   <= n_expect_rising;
            r_edge_since_tick <= n_edge_since_tick;
        end
    end

endmodule

// ===== sv/ipwfd_queue.sv =====
// Short event queue between the front end and the frame state machine.
// Depends on ipwfd_pkg for the event type and depth.
module ipwfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipwfd_pkg::t_ev_push i_push,
    input  logic                i_pop,
    output ipwfd_pkg::t_ev_push o_head,
    output logic                o_full
);
    import ipwfd_pkg::*;

    localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_event           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAW:0]     r_count, n_count;
    logic             do_pop;

    assign o_full      = (r_count == (QAW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ev    = r_mem[r_rd_ptr];
    assign do_pop      = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== sv/ipwfd_back.sv =====
// Back end: leader/header/bit state machine, byte packing and the result register.
// Depends on ipwfd_pkg and ipwfd_out_if; consumes the event queue.
module ipwfd_back #(
    parameter int unsigned FRAME_BYTES = ipwfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ipwfd_pkg::t_ev_push i_head,
    output logic                o_pop,
    ipwfd_out_if.source         o_res
);
    import ipwfd_pkg::*;

    localparam int unsigned BW = $clog2(FRAME_BYTES + 1);
    localparam logic [BW-1:0] FRAME_LIM = BW'(FRAME_BYTES);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_partial, n_partial;
    logic [2:0]      r_bit_idx, n_bit_idx;
    logic [BW-1:0]   r_byte_idx, n_byte_idx;
    t_result         r_res, n_res;
    logic            r_res_valid;

    t_event          ev;
    logic            take_bit;
    logic            bit_val;
    logic            frame_full;
    logic            store_bit;
    logic            byte_done;
    logic [3:0]      pos_ext;

    assign ev     = i_head.ev;
    assign o_pop  = i_head.valid && (!r_res_valid || o_res.ready);

    always_comb begin
        n_phase = r_phase;
        if (ev == EV_TIMEOUT) begin
            n_phase = PH_IDLE;
        end else if (ev != EV_NONE) begin
            case (r_phase)
                PH_IDLE: begin
                    n_phase = (ev == EV_LEAD_MARK) ? PH_LEADER : PH_IDLE;
                end
                PH_LEADER: begin
                    n_phase = (ev == EV_LEAD_SPACE) ? PH_HEADER : PH_IDLE;
                end
                PH_HEADER: begin
                    n_phase = (ev == EV_BIT_MARK) ? PH_BIT_MARK : PH_IDLE;
                end
                PH_BIT_MARK: begin
                    if (ev == EV_ONE_SPACE || ev == EV_ZERO_SPACE || ev == EV_REPEAT_GAP) begin
                        n_phase = PH_HEADER;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        take_bit   = (r_phase == PH_BIT_MARK) && (ev == EV_ONE_SPACE || ev == EV_ZERO_SPACE);
        bit_val    = (ev == EV_ONE_SPACE);
        frame_full = (r_byte_idx >= FRAME_LIM);
        store_bit  = take_bit && !frame_full;
        byte_done  = store_bit && (r_bit_idx == 3'd7);
        pos_ext    = 4'(r_byte_idx);

        n_partial  = r_partial;
        n_bit_idx  = r_bit_idx;
        n_byte_idx = r_byte_idx;

        n_res.event_code    = ev;
        n_res.decoder_phase = n_phase;
        n_res.bit_valid     = take_bit;
        n_res.bit_value     = take_bit && bit_val;
        n_res.byte_valid    = byte_done;
        n_res.byte_value    = '0;
        n_res.byte_position = '0;
        n_res.frame_end     = (ev == EV_TIMEOUT);
        n_res.overflow      = take_bit && frame_full;

        if (ev == EV_TIMEOUT) begin
            // drop the partial byte and restart the frame
            n_partial  = '0;
            n_bit_idx  = '0;
            n_byte_idx = '0;
        end else if (store_bit) begin
            n_partial = r_partial | (8'(bit_val) << r_bit_idx);
            n_bit_idx = r_bit_idx + 1'b1;
            if (byte_done) begin
                n_res.byte_value    = n_partial;
                n_res.byte_position = pos_ext[2:0];
                n_partial           = '0;
                n_byte_idx          = r_byte_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_partial   <= '0;
            r_bit_idx   <= '0;
            r_byte_idx  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_partial   <= n_partial;
                r_bit_idx   <= n_bit_idx;
                r_byte_idx  <= n_byte_idx;
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_res_valid;
    assign o_res.event_code    = r_res.event_code;
    assign o_res.decoder_phase = r_res.decoder_phase;
    assign o_res.bit_valid     = r_res.bit_valid;
    assign o_res.bit_value     = r_res.bit_value;
    assign o_res.byte_valid    = r_res.byte_valid;
    assign o_res.byte_value    = r_res.byte_value;
    assign o_res.byte_position = r_res.byte_position;
    assign o_res.frame_end     = r_res.frame_end;
    assign o_res.overflow      = r_res.overflow;

    a_byte_implies_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.byte_valid) |-> (r_res.bit_valid && !r_res.overflow))
        else $error("byte completed without a stored bit");

    a_byte_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= FRAME_LIM)
        else $error("byte count beyond frame size");

    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && ev == EV_TIMEOUT) |=>
        (r_phase == PH_IDLE && r_bit_idx == '0 && r_byte_idx == '0 && r_partial == '0))
        else $error("timeout did not clear the frame");

    a_bit_only_in_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_res.bit_valid) |=> (r_phase == PH_HEADER))
        else $error("decoded bit without return to header phase");

endmodule

// ===== sv/ir_pulse_width_frame_decoder.sv =====
// Top level of the IR pulse-width frame decoder: front end, event queue, frame state machine.
// Depends on ipwfd_pkg, ipwfd_in_if, ipwfd_out_if, ipwfd_front, ipwfd_queue, ipwfd_back.
//
//   Channel  Dir  Modport  Payload
//   i_in     in   sink     op, timestamp[TIME_WIDTH-1:0]
//   o_res    out  source   event_code, decoder_phase, bit/byte fields, frame_end, overflow
//
// One transaction per cycle sustained while results are taken; the event queue and then the
// result register hold each input (front end classifies and enqueues, state machine loads).
// Reset is synchronous, active low, and leaves the decoder idle with an empty frame.
// A stall on o_res fills the event queue, after which i_in.ready drops until a result
// is taken; the input side never waits on the output while queue space remains.
module ir_pulse_width_frame_decoder #(
    parameter int unsigned TIME_WIDTH  = ipwfd_pkg::TIME_WIDTH_DEF,
    parameter int unsigned FRAME_BYTES = ipwfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipwfd_in_if.sink    i_in,
    ipwfd_out_if.source o_res
);
    import ipwfd_pkg::*;

    t_ev_push push;
    t_ev_push head;
    logic     q_full;
    logic     pop;

    ipwfd_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    ipwfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    ipwfd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the IR pulse-width frame decoder: drives edge captures and ticks,
// predicts each result in a tracker class and checks the result channel in order.
// Depends on ipwfd_pkg, ipwfd_in_if, ipwfd_out_if and the ir_pulse_width_frame_decoder RTL.
module tb_top;
    import ipwfd_pkg::*;

    localparam bit          OP_EDGE        = 1'b0;
    localparam bit          OP_TICK        = 1'b1;
    localparam int unsigned FRAME_BYTES    = 5;
    localparam int unsigned LEAD_MARK_LO   = 6000;
    localparam int unsigned LEAD_MARK_HI   = 28000;
    localparam int unsigned BIT_MARK_LO    = 800;
    localparam int unsigned BIT_MARK_HI    = 4000;
    localparam int unsigned LEAD_SPACE_LO  = 5000;
    localparam int unsigned LEAD_SPACE_HI  = 12000;
    localparam int unsigned ONE_SPACE_LO   = 2100;
    localparam int unsigned ONE_SPACE_HI   = 4000;
    localparam int unsigned ZERO_SPACE_LO  = 400;
    localparam int unsigned ZERO_SPACE_HI  = 2000;
    localparam int unsigned GAP_LO         = 24000;
    localparam int unsigned GAP_HI         = 56000;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_ITEMS    = 560;

    class ir_frame_tracker;
        logic [15:0] last_edge;
        bit          armed;
        bit          expect_rising;
        bit          edge_since_tick;
        t_phase      phase;
        logic [7:0]  partial;
        int unsigned bit_idx;
        int unsigned byte_idx;
        t_result     expected_results[$];
        int unsigned errors;

        function new();
            last_edge       = '0;
            armed           = 1'b0;
            expect_rising   = 1'b0;
            edge_since_tick = 1'b0;
            phase           = PH_IDLE;
            partial         = '0;
            bit_idx         = 0;
            byte_idx        = 0;
            errors          = 0;
        endfunction

        static function bit in_window(int unsigned d, int unsigned lo, int unsigned hi);
            return d > lo && d < hi;
        endfunction

        function t_event classify(logic [15:0] ts);
            logic [15:0] diff;
            int unsigned d;
            edge_since_tick = 1'b1;
            if (!armed) begin
                armed         = 1'b1;
                last_edge     = ts;
                expect_rising = !expect_rising;
                return EV_NONE;
            end
            diff      = ts - last_edge;
            d         = 32'(diff);
            last_edge = ts;
            if (expect_rising) begin
                expect_rising = 1'b0;
                if (in_window(d, LEAD_MARK_LO, LEAD_MARK_HI)) return EV_LEAD_MARK;
                if (in_window(d, BIT_MARK_LO, BIT_MARK_HI)) return EV_BIT_MARK;
                return EV_NONE;
            end
            expect_rising = 1'b1;
            if (in_window(d, LEAD_SPACE_LO, LEAD_SPACE_HI)) return EV_LEAD_SPACE;
            if (in_window(d, ONE_SPACE_LO, ONE_SPACE_HI)) return EV_ONE_SPACE;
            if (in_window(d, ZERO_SPACE_LO, ZERO_SPACE_HI)) return EV_ZERO_SPACE;
            if (in_window(d, GAP_LO, GAP_HI)) return EV_REPEAT_GAP;
            return EV_NONE;
        endfunction

        function void take_bit(bit b, inout t_result r);
            r.bit_valid = 1'b1;
            r.bit_value = b;
            if (byte_idx >= FRAME_BYTES) begin
                r.overflow = 1'b1;
                return;
            end
            if (b) partial[bit_idx] = 1'b1;
            bit_idx++;
            if (bit_idx == 8) begin
                r.byte_valid    = 1'b1;
                r.byte_value    = partial;
                r.byte_position = byte_idx[2:0];
                byte_idx++;
                bit_idx = 0;
                partial = '0;
            end
        endfunction

        function void note_capture(bit op, logic [15:0] ts);
            t_result r;
            t_event  ev;
            r  = '0;
            ev = EV_NONE;
            if (op == OP_TICK) begin
                if (!edge_since_tick) begin
                    expect_rising = 1'b0;
                    armed         = 1'b0;
                    ev            = EV_TIMEOUT;
                end
                edge_since_tick = 1'b0;
            end else begin
                ev = classify(ts);
            end
            if (ev == EV_TIMEOUT) begin
                phase       = PH_IDLE;
                partial     = '0;
                bit_idx     = 0;
                byte_idx    = 0;
                r.frame_end = 1'b1;
            end else if (ev != EV_NONE) begin
                case (phase)
                    PH_IDLE:   phase = (ev == EV_LEAD_MARK) ? PH_LEADER : PH_IDLE;
                    PH_LEADER: phase = (ev == EV_LEAD_SPACE) ? PH_HEADER : PH_IDLE;
                    PH_HEADER: phase = (ev == EV_BIT_MARK) ? PH_BIT_MARK : PH_IDLE;
                    default: begin
                        case (ev)
                            EV_ONE_SPACE: begin
                                phase = PH_HEADER;
                                take_bit(1'b1, r);
                            end
                            EV_ZERO_SPACE: begin
                                phase = PH_HEADER;
                                take_bit(1'b0, r);
                            end
                            EV_REPEAT_GAP: phase = PH_HEADER;
                            default:       phase = PH_IDLE;
                        endcase
                    end
                endcase
            end
            r.event_code    = ev;
            r.decoder_phase = phase;
            expected_results.push_back(r);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%s mismatch: expected %0d, got %0d", field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with none outstanding: event %0d", got.event_code);
                return;
            end
            want = expected_results.pop_front();
            compare("event_code", 8'(want.event_code), 8'(got.event_code));
            compare("decoder_phase", 8'(want.decoder_phase), 8'(got.decoder_phase));
            compare("bit_valid", 8'(want.bit_valid), 8'(got.bit_valid));
            compare("bit_value", 8'(want.bit_value), 8'(got.bit_value));
            compare("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            compare("byte_value", want.byte_value, got.byte_value);
            compare("byte_position", 8'(want.byte_position), 8'(got.byte_position));
            compare("frame_end", 8'(want.frame_end), 8'(got.frame_end));
            compare("overflow", 8'(want.overflow), 8'(got.overflow));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ipwfd_in_if  in_ch ();
    ipwfd_out_if res_ch ();

    ir_pulse_width_frame_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    ir_frame_tracker tracker;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     items_sent;
    int unsigned     idle_cycles;
    bit              hold_req;
    logic [15:0]     edge_ts;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic put_item(bit op, logic [15:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.timestamp <= ts;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic edge_after(logic [15:0] gap);
        edge_ts = edge_ts + gap;
        put_item(OP_EDGE, edge_ts);
    endtask

    task automatic send_tick();
        put_item(OP_TICK, 16'($urandom));
    endtask

    function automatic logic [15:0] pick(int unsigned lo, int unsigned hi);
        return 16'($urandom_range(hi - 1, lo + 1));
    endfunction

    // Well-formed frame with random bits, broken now and then by ticks, gaps or stray edges
    task automatic random_frame();
        int unsigned nbits;
        nbits = ($urandom_range(3) == 0) ? $urandom_range(48, 41) : $urandom_range(40, 1);
        send_tick();
        send_tick();
        edge_after(16'($urandom));
        edge_after(pick(LEAD_MARK_LO, LEAD_MARK_HI));
        edge_after(pick(LEAD_SPACE_LO, LEAD_SPACE_HI));
        edge_after(pick(BIT_MARK_LO, BIT_MARK_HI));
        repeat (nbits) begin
            case ($urandom_range(19))
                0: send_tick();
                1: begin
                    edge_after(pick(GAP_LO, GAP_HI));
                    edge_after(pick(BIT_MARK_LO, BIT_MARK_HI));
                end
                2: edge_after(16'($urandom));
                default: ;
            endcase
            if ($urandom_range(1))
                edge_after(pick(ONE_SPACE_LO, ONE_SPACE_HI));
            else
                edge_after(pick(ZERO_SPACE_LO, ZERO_SPACE_HI));
            edge_after(pick(BIT_MARK_LO, BIT_MARK_HI));
        end
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned goal;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(8, 1))
                    put_item(bit'($urandom_range(1)), 16'($urandom));
            end else begin
                random_frame();
            end
        end
    endtask

    initial begin
        int unsigned stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && stall_left == 0) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left != 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_capture(in_ch.op, in_ch.timestamp);
            if (res_ch.valid && res_ch.ready) begin
                seen = '{event_code: res_ch.event_code, decoder_phase: res_ch.decoder_phase,
                         bit_valid: res_ch.bit_valid, bit_value: res_ch.bit_value,
                         byte_valid: res_ch.byte_valid, byte_value: res_ch.byte_value,
                         byte_position: res_ch.byte_position, frame_end: res_ch.frame_end,
                         overflow: res_ch.overflow};
                tracker.check_result(seen);
            end
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        tracker         = new();
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_EDGE;
        in_ch.timestamp = '0;
        i_rst_n         = 1'b0;
        send_idle_pct   = 20;
        recv_idle_pct   = 50;
        hold_req        = 1'b0;
        items_sent      = 0;
        idle_cycles     = 0;
        edge_ts         = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // window edges, every event, wrap-round and timeouts
        send_tick();
        edge_ts = 16'hFFFF;
        put_item(OP_EDGE, edge_ts);
        edge_after(16'(LEAD_MARK_LO + 1));
        edge_after(16'(LEAD_SPACE_HI - 1));
        edge_after(16'(BIT_MARK_HI - 1));
        edge_after(16'(ONE_SPACE_LO + 1));
        edge_after(16'(BIT_MARK_LO + 1));
        edge_after(16'(ZERO_SPACE_HI - 1));
        edge_after(16'(BIT_MARK_LO + 1));
        edge_after(16'(GAP_HI - 1));
        edge_after(16'(BIT_MARK_HI - 1));
        edge_after(16'(ONE_SPACE_HI - 1));
        edge_after(16'(LEAD_MARK_HI - 1));
        edge_after(16'(ZERO_SPACE_LO + 1));
        edge_after(16'(BIT_MARK_HI));
        edge_after(16'(GAP_LO + 1));
        edge_after(16'h0000);
        edge_after(16'hFFFF);
        send_tick();
        send_tick();
        send_tick();
        edge_ts = 16'h0000;
        put_item(OP_EDGE, edge_ts);
        edge_after(16'(LEAD_MARK_LO));
        edge_after(16'(LEAD_SPACE_LO));

        run_phase(PHASE_ITEMS);
        send_idle_pct = 50;
        recv_idle_pct = 20;
        run_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_phase(PHASE_ITEMS);
        in_ch.valid <= 1'b0;

        while (tracker.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
